/* rtl/tif_pkg.sv */
`default_nettype none

package tif_pkg;

    // Stream widths
    localparam int unsigned ByteW   = 8;
    localparam int unsigned InDataW = 16;   // in_byte, link_up, zero fill
    localparam int unsigned OutDataW = 8;   // out_byte

    // Telnet command bytes
    localparam logic [ByteW-1:0] B_IAC  = 8'hFF;
    localparam logic [ByteW-1:0] B_WILL = 8'hFB;
    localparam logic [ByteW-1:0] B_WONT = 8'hFC;
    localparam logic [ByteW-1:0] B_DO   = 8'hFD;
    localparam logic [ByteW-1:0] B_DONT = 8'hFE;
    localparam logic [ByteW-1:0] B_SB   = 8'hFA;
    localparam logic [ByteW-1:0] B_SE   = 8'hF0;

    // Destination flag on the result stream
    localparam logic DEST_TERM = 1'b0;
    localparam logic DEST_NET  = 1'b1;

    // Results held per input byte
    localparam logic [1:0] CNT_NONE  = 2'd0;
    localparam logic [1:0] CNT_DATA  = 2'd1;
    localparam logic [1:0] CNT_REPLY = 2'd3;

endpackage

`default_nettype wire

/* rtl/telnet_iac_filter_unit.sv */
`default_nettype none

// Channel  | Direction | Signals                                 | Payload
// ---------+-----------+-----------------------------------------+-----------------------------
// s (in)   | slave     | i_s_tvalid o_s_tready i_s_tdata         | in_byte, link_up
// m (out)  | master    | o_m_tvalid i_m_tready o_m_tdata/tuser/  | out_byte, out_dest, out_last
//          |           | tlast                                   |
//
// One byte is taken every cycle while the result register is free or is
// handing over its final result in that cycle. A data byte gives one result
// the cycle after its transfer; a refusal with link_up set gives three
// results; the burst register holds off the input until the last leaves.
// Reset (i_rst_n low, synchronous) returns the negotiation state to normal
// and empties the burst register. A stalled result holds all output fields.

module telnet_iac_filter_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave side
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [tif_pkg::InDataW-1:0]   i_s_tdata,   // [7:0] in_byte, [8] link_up
    // master side
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [tif_pkg::OutDataW-1:0]       o_m_tdata,   // [7:0] out_byte
    output logic                               o_m_tuser,   // [0] out_dest
    output logic                               o_m_tlast    // out_last
);

    typedef enum logic [2:0] {
        ST_NORMAL,
        ST_IAC,
        ST_WILL,
        ST_WONT,
        ST_DO,
        ST_DONT,
        ST_SUB,
        ST_SUBIAC
    } t_state;

    t_state r_state, n_state;

    // burst register: up to three results, shifted out from r_b0
    logic [1:0]                 r_cnt,  n_cnt;
    logic                       r_dest, n_dest;
    logic [tif_pkg::ByteW-1:0]  r_b0, r_b1, r_b2;
    logic [tif_pkg::ByteW-1:0]  n_b0, n_b1, n_b2;

    logic                       in_xfer;
    logic                       out_xfer;
    logic [tif_pkg::ByteW-1:0]  in_byte;
    logic                       link_up;

    assign in_byte = i_s_tdata[tif_pkg::ByteW-1:0];
    assign link_up = i_s_tdata[tif_pkg::ByteW];

    // free now, or the last pending result leaves this cycle
    assign o_s_tready = (r_cnt == tif_pkg::CNT_NONE) ||
                        ((r_cnt == tif_pkg::CNT_DATA) && i_m_tready);
    assign in_xfer    = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = (r_cnt != tif_pkg::CNT_NONE);
    assign o_m_tdata  = r_b0;
    assign o_m_tuser  = r_dest;
    assign o_m_tlast  = (r_cnt == tif_pkg::CNT_DATA);
    assign out_xfer   = o_m_tvalid && i_m_tready;

    // negotiation step and burst load
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dest  = r_dest;
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_b2    = r_b2;

        // drain one result
        if (out_xfer) begin
            n_cnt = r_cnt - 2'd1;
            n_b0  = r_b1;
            n_b1  = r_b2;
        end

        if (in_xfer) begin
            n_cnt = tif_pkg::CNT_NONE;
            unique case (r_state)
                ST_NORMAL: begin
                    if (in_byte == tif_pkg::B_IAC) begin
                        n_state = ST_IAC;
                    end else begin
                        n_cnt  = tif_pkg::CNT_DATA;
                        n_dest = tif_pkg::DEST_TERM;
                        n_b0   = in_byte;
                    end
                end
                ST_IAC: begin
                    n_state = ST_NORMAL;
                    case (in_byte)
                        tif_pkg::B_IAC: begin
                            n_cnt  = tif_pkg::CNT_DATA;
                            n_dest = tif_pkg::DEST_TERM;
                            n_b0   = tif_pkg::B_IAC;
                        end
                        tif_pkg::B_WILL: n_state = ST_WILL;
                        tif_pkg::B_WONT: n_state = ST_WONT;
                        tif_pkg::B_DO:   n_state = ST_DO;
                        tif_pkg::B_DONT: n_state = ST_DONT;
                        tif_pkg::B_SB:   n_state = ST_SUB;
                        default:         n_state = ST_NORMAL;
                    endcase
                end
                ST_WILL, ST_DO: begin
                    // refuse the option toward the network
                    if (link_up) begin
                        n_cnt  = tif_pkg::CNT_REPLY;
                        n_dest = tif_pkg::DEST_NET;
                        n_b0   = tif_pkg::B_IAC;
                        n_b1   = (r_state == ST_WILL) ? tif_pkg::B_DONT : tif_pkg::B_WONT;
                        n_b2   = in_byte;
                    end
                    n_state = ST_NORMAL;
                end
                ST_WONT, ST_DONT: begin
                    n_state = ST_NORMAL;
                end
                ST_SUB: begin
                    if (in_byte == tif_pkg::B_IAC) begin
                        n_state = ST_SUBIAC;
                    end
                end
                ST_SUBIAC: begin
                    // escaped IAC keeps the escape state
                    if (in_byte == tif_pkg::B_SE) begin
                        n_state = ST_NORMAL;
                    end else if (in_byte != tif_pkg::B_IAC) begin
                        n_state = ST_SUB;
                    end
                end
                default: n_state = ST_NORMAL;
            endcase
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NORMAL;
            r_cnt   <= tif_pkg::CNT_NONE;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_dest <= n_dest;
        r_b0   <= n_b0;
        r_b1   <= n_b1;
        r_b2   <= n_b2;
    end

endmodule

`default_nettype wire

/* rtl/tif_checker.sv */
`default_nettype none

module tif_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic [tif_pkg::InDataW-1:0]   i_s_tdata,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [tif_pkg::OutDataW-1:0]  o_m_tdata,
    input wire logic                          o_m_tuser,
    input wire logic                          o_m_tlast
);

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // terminal data is always a single result
    a_data_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == tif_pkg::DEST_TERM) |-> o_m_tlast)
        else $error("terminal byte without last");

    // a reply burst continues without gaps once started
    a_reply_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && (o_m_tuser == tif_pkg::DEST_NET) && !o_m_tlast |=>
            o_m_tvalid && (o_m_tuser == tif_pkg::DEST_NET))
        else $error("reply burst broken");

    // input is held off only while results are pending
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !(i_m_tready && o_m_tlast))
        else $error("input stalled with no pending result");

    logic unused_in;
    assign unused_in = i_s_tvalid ^ (^i_s_tdata);

endmodule

bind telnet_iac_filter_unit tif_checker u_tif_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
